>>> hw/rtl/hptt_pkg.sv
// Shared types, constants and helpers for the hashed periodic timer table.
// Used by hptt_hash and hashed_periodic_timer_table; no dependencies.
package hptt_pkg;

	localparam int unsigned SLOTS_DEF = 64;
	localparam int unsigned MAX_OUT   = 64;
	localparam int unsigned CNT_W     = $clog2(MAX_OUT + 1);
	localparam int unsigned SLOT_O_W  = 6;
	localparam logic [63:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2    = 64'h94d049bb133111eb;
	localparam logic [63:0] MS_NS     = 64'd1000000;
	// ceil(2^72 / 15625): (x >> 6) * MS_RECIP >> 72 equals x / 1000000 for any 64-bit x.
	localparam logic [63:0] MS_RECIP  = 64'd302231454903657294;
	localparam logic [31:0] IDLE_WAIT_RST = 32'd1000000;

	typedef enum logic [1:0] {
		FN_SNAP  = 2'd0,
		FN_START = 2'd1,
		FN_SCAN  = 2'd2,
		FN_STOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KD_SNAP = 2'd0,
		KD_FIRE = 2'd1,
		KD_IDLE = 2'd2,
		KD_STOP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] last_time;
		logic [63:0] ticks;
		logic [63:0] period;
		logic [63:0] due;
		logic        used;
		logic        armed;
	} entry_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

>>> hw/rtl/hptt_hash.sv
// Iterative 64-bit finalizer of the token: one 32x32 partial product a cycle.
// Depends on hptt_pkg for the mixing constants.
module hptt_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] token,
	output logic        done,
	output logic [63:0] value
);

	logic [63:0] v_q;
	logic [63:0] acc_q;
	logic [1:0]  ph_q;
	logic        round_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] c;
	logic [31:0] opa, opb;
	logic [63:0] prod;
	logic [63:0] acc_n;

	always_comb begin
		c    = round_q ? hptt_pkg::MIX_C2 : hptt_pkg::MIX_C1;
		opa  = (ph_q == 2'd2) ? v_q[63:32] : v_q[31:0];
		opb  = (ph_q == 2'd1) ? c[63:32] : c[31:0];
		prod = {32'b0, opa} * {32'b0, opb};
		if (ph_q == 2'd0) begin
			acc_n = prod;
		end else begin
			acc_n = acc_q + {prod[31:0], 32'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			ph_q    <= 2'd0;
			round_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q     <= token ^ (token >> 30);
				ph_q    <= 2'd0;
				round_q <= 1'b0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_n;
				if (ph_q == 2'd2) begin
					ph_q <= 2'd0;
					if (!round_q) begin
						v_q     <= acc_n ^ (acc_n >> 27);
						round_q <= 1'b1;
					end else begin
						v_q    <= acc_n ^ (acc_n >> 31);
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end
		end
	end

	assign done  = done_q;
	assign value = v_q;

endmodule

>>> hw/rtl/hptt_div.sv
// Restoring 64-bit divider, one quotient bit a cycle, used for the tick advance
// (elapsed time over the interval). No dependencies.
module hptt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] t;
	logic        ge;

	always_comb begin
		t  = {rem_q, quo_q[63]};
		ge = t >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= 64'd0;
				quo_q  <= dividend;
				d_q    <= divisor;
				cnt_q  <= 7'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? 64'(t - {1'b0, d_q}) : t[63:0];
				quo_q <= {quo_q[62:0], ge};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/hashed_periodic_timer_table.sv
// Top level of the hashed periodic timer table: slot memory, sequencer, output register.
// Depends on hptt_pkg, hptt_hash and hptt_div.
//
// channel   direction  handshake                 payload
// s_*       in         s_tvalid / s_tready       tdata: token, interval, jitter, now_ns; tuser: func
// m_*       out        m_tvalid / m_tready       tdata: result fields; tuser: kind; tlast: last
// cfg_*     in         cfg_valid / cfg_ready     cfg_data: idle_wait_ns
//
// One item is worked at a time; the slot memory has one read and one write port.
// Snapshot: hashing, a read and a check per probe, up to one division, the millisecond
// conversion and one write. Start: hashing, probes and one write. Scan and stop: a read
// and a check or write per slot, then the result. After reset a clearing pass zeroes
// every slot before any item is taken. A result waits in the output register; each result
// state, and a scan that finds a further fire, stalls while it holds an unread result.
module hashed_periodic_timer_table #(
	// The home slot is the masked hash; the user must keep SLOTS a power of two (unchecked).
	parameter int unsigned SLOTS = hptt_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,  // token[63:0], interval, jitter, now_ns
	input  logic [1:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [279:0] m_tdata,  // tick, elapsed_ms, missed, fired_slot, wait_ns, total_fires
	output logic [1:0]   m_tuser,  // kind
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	localparam int unsigned IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [18:0] {
		S_CLR    = 19'h00001,
		S_IDLE   = 19'h00002,
		S_HASH   = 19'h00004,
		S_FD_RD  = 19'h00010,
		S_FD_CHK = 19'h00020,
		S_FD_HRD = 19'h00040,
		S_FD_HCK = 19'h00080,
		S_SN_A   = 19'h00100,
		S_SN_DV  = 19'h00200,
		S_SN_MS  = 19'h00400,
		S_SN_OUT = 19'h00800,
		S_ST_OUT = 19'h01000,
		S_SC_RD  = 19'h02000,
		S_SC_CHK = 19'h04000,
		S_SC_END = 19'h08000,
		S_SP_RD  = 19'h10000,
		S_SP_WR  = 19'h20000,
		S_SP_OUT = 19'h40000
	} state_t;

	state_t state_q;

	hptt_pkg::entry_t mem [SLOTS];
	hptt_pkg::entry_t rdata_q;
	hptt_pkg::entry_t e_q;
	hptt_pkg::entry_t wdata;
	logic             mem_we;
	logic [IW-1:0]    waddr, raddr;

	logic [1:0]    func_q;
	logic [63:0]   token_q, intv_q, jitter_q, now_q;
	logic [31:0]   idle_wait_q, wait_q;
	logic [63:0]   fire_total_q;
	logic [IW-1:0] i_q, idx_q, home_q, s_q, p_q;
	logic [hptt_pkg::CNT_W-1:0] n_q;
	logic          pend_v_q;
	logic [IW-1:0] pend_slot_q;
	logic [63:0]   pend_total_q;
	logic [63:0]   elapsed_q, adv_q, ems_q;

	logic [1:0]    mph_q;
	logic [127:0]  macc_q, macc_n;
	logic [57:0]   ms_y;
	logic [31:0]   ms_a, ms_b;
	logic [63:0]   ms_p;

	logic          m_tvalid_q, o_last_q;
	logic [1:0]    o_kind_q;
	logic [63:0]   o_tick_q, o_missed_q, o_total_q;
	logic [44:0]   o_ems_q;
	logic [5:0]    o_slot_q;
	logic [31:0]   o_wait_q;

	logic          hash_start, hash_done;
	logic [63:0]   hash_val;
	logic          div_start, div_done;
	logic [63:0]   div_a, div_b, div_q;

	logic          out_free, in_acc, o_load;
	logic          active, due_now, sc_report, sc_go;
	logic [63:0]   diff, elapsed_c, missed_c;
	logic [63:0]   s_intv;

	hptt_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start), .token(s_tdata[63:0]),
		.done(hash_done), .value(hash_val)
	);

	hptt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign s_intv    = (s_tdata[127:64] == 64'd0) ? 64'd1 : s_tdata[127:64];

	always_comb begin
		active    = rdata_q.used && rdata_q.armed;
		due_now   = rdata_q.due <= now_q;
		diff      = rdata_q.due - now_q;
		sc_report = active && due_now && (n_q < hptt_pkg::CNT_W'(hptt_pkg::MAX_OUT));
		sc_go     = !(sc_report && pend_v_q && !out_free);
		elapsed_c = (now_q >= e_q.last_time) ? now_q - e_q.last_time : 64'd0;
		missed_c  = ((adv_q > 64'd1) && (elapsed_q > hptt_pkg::sat_add(intv_q, jitter_q)))
			? adv_q - 64'd1 : 64'd0;
		o_load    = ((state_q == S_SN_OUT) || (state_q == S_ST_OUT) || (state_q == S_SC_END)
			|| (state_q == S_SP_OUT)) ? out_free
			: ((state_q == S_SC_CHK) && sc_go && sc_report && pend_v_q);
		// Millisecond conversion: four 32x32 partial products of (elapsed >> 6) * MS_RECIP.
		ms_y = elapsed_q[63:6];
		ms_a = mph_q[1] ? {6'b0, ms_y[57:32]} : ms_y[31:0];
		ms_b = mph_q[0] ? {5'b0, hptt_pkg::MS_RECIP[58:32]} : hptt_pkg::MS_RECIP[31:0];
		ms_p = {32'b0, ms_a} * {32'b0, ms_b};
		case (mph_q)
			2'd0: macc_n = {64'b0, ms_p};
			2'd3: macc_n = macc_q + {ms_p, 64'b0};
			default: macc_n = macc_q + {32'b0, ms_p, 32'b0};
		endcase
	end

	// Memory port, hash start and divider control, per state.
	always_comb begin
		mem_we     = 1'b0;
		waddr      = i_q;
		wdata      = rdata_q;
		raddr      = idx_q;
		div_start  = 1'b0;
		div_a      = elapsed_q;
		div_b      = intv_q;
		hash_start = in_acc && ((s_tuser == hptt_pkg::FN_SNAP) || (s_tuser == hptt_pkg::FN_START));
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				wdata  = '0;
			end
			S_FD_HRD: raddr = home_q;
			S_SN_A: begin
				div_start = (e_q.last_time != 64'd0);
				div_a     = elapsed_c;
			end
			S_SN_OUT: begin
				mem_we = out_free;
				waddr  = s_q;
				wdata  = e_q;
			end
			S_ST_OUT: begin
				mem_we       = out_free;
				waddr        = s_q;
				wdata        = e_q;
				wdata.period = intv_q;
				wdata.due    = hptt_pkg::sat_add(now_q, intv_q);
				wdata.armed  = 1'b1;
			end
			S_SC_RD, S_SP_RD: raddr = i_q;
			S_SC_CHK: begin
				raddr     = i_q;
				mem_we    = sc_go && active && due_now;
				wdata.due = hptt_pkg::sat_add(now_q, rdata_q.period);
			end
			S_SP_WR: begin
				mem_we      = 1'b1;
				wdata.armed = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			i_q          <= '0;
			idle_wait_q  <= hptt_pkg::IDLE_WAIT_RST;
			fire_total_q <= 64'd0;
			m_tvalid_q   <= 1'b0;
			pend_v_q     <= 1'b0;
			n_q          <= '0;
			mph_q        <= 2'd0;
		end else begin
			if (cfg_valid) begin
				idle_wait_q <= cfg_data;
			end
			if (o_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					i_q <= i_q + IW'(1);
					if (i_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						func_q   <= s_tuser;
						token_q  <= s_tdata[63:0];
						intv_q   <= s_intv;
						jitter_q <= s_tdata[191:128];
						now_q    <= s_tdata[255:192];
						i_q      <= '0;
						n_q      <= '0;
						pend_v_q <= 1'b0;
						wait_q   <= idle_wait_q;
						mph_q    <= 2'd0;
						case (s_tuser)
							hptt_pkg::FN_SCAN: state_q <= S_SC_RD;
							hptt_pkg::FN_STOP: state_q <= S_SP_RD;
							default: state_q <= S_HASH;
						endcase
					end
				end
				S_HASH: begin
					if (hash_done) begin
						home_q  <= hash_val[IW-1:0];
						idx_q   <= hash_val[IW-1:0];
						p_q     <= '0;
						state_q <= S_FD_RD;
					end
				end
				S_FD_RD: state_q <= S_FD_CHK;
				S_FD_CHK: begin
					// A free slot is claimed; a matching key is reused.
					if (!rdata_q.used) begin
						e_q     <= '{key: token_q, last_time: 64'd0, ticks: 64'd0,
							period: 64'd0, due: 64'd0, used: 1'b1, armed: 1'b0};
						s_q     <= idx_q;
						state_q <= (func_q == hptt_pkg::FN_SNAP) ? S_SN_A : S_ST_OUT;
					end else if (rdata_q.key == token_q) begin
						e_q     <= rdata_q;
						s_q     <= idx_q;
						state_q <= (func_q == hptt_pkg::FN_SNAP) ? S_SN_A : S_ST_OUT;
					end else if (p_q == LAST_IDX) begin
						state_q <= S_FD_HRD;
					end else begin
						p_q     <= p_q + IW'(1);
						idx_q   <= (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
						state_q <= S_FD_RD;
					end
				end
				S_FD_HRD: state_q <= S_FD_HCK;
				S_FD_HCK: begin
					e_q     <= rdata_q;
					s_q     <= home_q;
					state_q <= (func_q == hptt_pkg::FN_SNAP) ? S_SN_A : S_ST_OUT;
				end
				S_SN_A: begin
					if (e_q.last_time == 64'd0) begin
						e_q.last_time <= now_q;
						e_q.ticks     <= 64'd0;
						elapsed_q     <= intv_q;
						adv_q         <= 64'd1;
						state_q       <= S_SN_MS;
					end else begin
						elapsed_q <= elapsed_c;
						state_q   <= S_SN_DV;
					end
				end
				S_SN_DV: begin
					if (div_done) begin
						adv_q <= div_q;
						if (div_q != 64'd0) begin
							e_q.ticks     <= e_q.ticks + div_q;
							e_q.last_time <= now_q;
						end
						state_q <= S_SN_MS;
					end
				end
				S_SN_MS: begin
					macc_q <= macc_n;
					mph_q  <= mph_q + 2'd1;
					if (mph_q == 2'd3) begin
						ems_q   <= {19'b0, macc_n[116:72]};
						state_q <= S_SN_OUT;
					end
				end
				S_SN_OUT: begin
					if (out_free) begin
						o_kind_q   <= hptt_pkg::KD_SNAP;
						o_tick_q   <= e_q.ticks;
						o_ems_q    <= ems_q[44:0];
						o_missed_q <= missed_c;
						o_slot_q   <= '0;
						o_wait_q   <= '0;
						o_total_q  <= fire_total_q;
						o_last_q   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_ST_OUT: begin
					if (out_free) begin
						fire_total_q <= fire_total_q + 64'd1;
						o_kind_q     <= hptt_pkg::KD_FIRE;
						o_tick_q     <= '0;
						o_ems_q      <= '0;
						o_missed_q   <= '0;
						o_slot_q     <= hptt_pkg::SLOT_O_W'(s_q);
						o_wait_q     <= '0;
						o_total_q    <= fire_total_q + 64'd1;
						o_last_q     <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SC_RD: state_q <= S_SC_CHK;
				S_SC_CHK: begin
					if (sc_go) begin
						// A fire is held back one step so the final one can carry last.
						if (sc_report) begin
							if (pend_v_q) begin
								o_kind_q   <= hptt_pkg::KD_FIRE;
								o_tick_q   <= '0;
								o_ems_q    <= '0;
								o_missed_q <= '0;
								o_slot_q   <= hptt_pkg::SLOT_O_W'(pend_slot_q);
								o_wait_q   <= '0;
								o_total_q  <= pend_total_q;
								o_last_q   <= 1'b0;
							end
							pend_v_q     <= 1'b1;
							pend_slot_q  <= i_q;
							pend_total_q <= fire_total_q + 64'd1;
							fire_total_q <= fire_total_q + 64'd1;
							n_q          <= n_q + hptt_pkg::CNT_W'(1);
						end else if (active && !due_now && (diff < {32'b0, wait_q})) begin
							wait_q <= diff[31:0];
						end
						if (i_q == LAST_IDX) begin
							state_q <= S_SC_END;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_SC_RD;
						end
					end
				end
				S_SC_END: begin
					if (out_free) begin
						o_tick_q   <= '0;
						o_ems_q    <= '0;
						o_missed_q <= '0;
						o_last_q   <= 1'b1;
						if (pend_v_q) begin
							o_kind_q  <= hptt_pkg::KD_FIRE;
							o_slot_q  <= hptt_pkg::SLOT_O_W'(pend_slot_q);
							o_wait_q  <= '0;
							o_total_q <= pend_total_q;
						end else begin
							o_kind_q  <= hptt_pkg::KD_IDLE;
							o_slot_q  <= '0;
							o_wait_q  <= wait_q;
							o_total_q <= fire_total_q;
						end
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_SP_RD: state_q <= S_SP_WR;
				S_SP_WR: begin
					if (i_q == LAST_IDX) begin
						state_q <= S_SP_OUT;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_SP_RD;
					end
				end
				S_SP_OUT: begin
					if (out_free) begin
						o_kind_q   <= hptt_pkg::KD_STOP;
						o_tick_q   <= '0;
						o_ems_q    <= '0;
						o_missed_q <= '0;
						o_slot_q   <= '0;
						o_wait_q   <= '0;
						o_total_q  <= fire_total_q;
						o_last_q   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'b0, o_total_q, o_wait_q, o_slot_q, o_missed_q, o_ems_q, o_tick_q};

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("slot memory written while idle");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= hptt_pkg::CNT_W'(hptt_pkg::MAX_OUT))
		else $error("scan reported more fires than allowed");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("accepted item did not start work");

	a_fire_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && $past(!m_tvalid_q) && (o_kind_q == hptt_pkg::KD_FIRE))
		|-> (o_total_q != 64'd0))
		else $error("fire reported with zero total");

endmodule
